### rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants and sRGB curve tables for the mip box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int LINEAR_BITS = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int SRC_W_W     = COL_W + 1;
  localparam int PAIR_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(PAIR_DEPTH);
  localparam int LIN_W       = LINEAR_BITS;
  localparam int PAIR_W      = LIN_W + 1;
  localparam int TOT_W       = LIN_W + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 16;
  localparam int ENC_STEPS   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRGB_MODE  = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_of_image;
  } pix_out_t;

  typedef struct packed {
    logic [SRC_W_W-1:0] src_width;
    logic [ROW_W-1:0]   src_height;
    logic               srgb_mode;
  } cfg_t;

  typedef struct packed {
    logic [LIN_W-1:0] r;
    logic [LIN_W-1:0] g;
    logic [LIN_W-1:0] b;
    logic [7:0]       a;
  } lin_pix_t;

  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
    logic [8:0]        a;
  } pair_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_COMBINE,
    OP_DIRECT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    pair_t             pair;
    logic              last;
  } item_t;

  // curve constants in fixed point
  localparam logic [63:0] LinScale = (64'd1 << LINEAR_BITS) - 64'd1;
  localparam logic [63:0] Q30One   = 64'd1 << 30;
  localparam logic [63:0] LoDen    = 64'd658920;   // 510 * 1292
  localparam logic [63:0] LoDen2   = 64'd1317840;
  localparam logic [63:0] CurveDen = 64'd538050;

  // Linear value of sRGB level n/510, evaluated at elaboration only.
  function automatic logic [LIN_W-1:0] level_to_linear(input logic [8:0] n);
    logic [63:0] nn;
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] res;
    nn = {55'd0, n};
    if (nn <= 64'd20) begin
      res = (nn * 64'd200 * LinScale + LoDen) / LoDen2;
    end else begin
      x  = ((64'd1000 * nn + 64'd28050) << 30) / CurveDen;
      q  = (x * x) >> 30;
      lo = 64'd0;
      hi = Q30One;
      for (int i = 0; i < 40; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p   = (mid * mid) >> 30;
          p   = (p * mid) >> 30;
          p   = (p * mid) >> 30;
          p   = (p * mid) >> 30;
          if (p <= q) lo = mid;
          else        hi = mid - 64'd1;
        end
      end
      y   = (q * lo) >> 30;
      res = (y * LinScale + (Q30One >> 1)) >> 30;
    end
    return res[LIN_W-1:0];
  endfunction

  function automatic logic [255:0][LIN_W-1:0] build_lin_tab();
    logic [255:0][LIN_W-1:0] t;
    for (int k = 0; k < 256; k++) t[k] = level_to_linear(9'(2 * k));
    return t;
  endfunction

  function automatic logic [255:0][LIN_W-1:0] build_thr_tab();
    logic [255:0][LIN_W-1:0] t;
    t[0] = '0;
    for (int k = 1; k < 256; k++) t[k] = level_to_linear(9'(2 * k - 1));
    return t;
  endfunction

  // code -> linear, and rising thresholds of the inverse curve
  localparam logic [255:0][LIN_W-1:0] LIN_TAB = build_lin_tab();
  localparam logic [255:0][LIN_W-1:0] THR_TAB = build_thr_tab();

endpackage

### rtl/mbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_queue
// Short item queue between the classifier front and the filter back.
// ----------------------------------------------------------------------------
module mbd_queue import mbd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

### rtl/mbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_front
// Tracks raster position, decodes pixels to linear, pairs columns and
// classifies each pair as row store, row combine or direct emit.
// ----------------------------------------------------------------------------
module mbd_front import mbd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    restart,
  input  logic    in_push,
  input  pix_in_t in_data,
  input  logic    q_full,
  output logic    q_push,
  output item_t   q_item
);

  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   row_nxt;
  lin_pix_t           hold_r;

  logic               accept;
  logic [SRC_W_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [COL_W-1:0]   nw;
  logic [ROW_W-1:0]   nh;
  logic               w_one;
  logic               h_one;
  lin_pix_t           v;
  pair_t              pair;
  logic               have_pair;
  logic               hold_en;
  logic [ADDR_W-1:0]  nx;
  logic [ROW_W-2:0]   ny;

  assign accept = in_push && !q_full;

  always_comb begin
    if (cfg.src_width == '0)                              w_eff = SRC_W_W'(1);
    else if (cfg.src_width > SRC_W_W'(MAX_WIDTH))         w_eff = SRC_W_W'(MAX_WIDTH);
    else                                                  w_eff = cfg.src_width;
    h_eff = (cfg.src_height == '0) ? ROW_W'(1) : cfg.src_height;
    w_one = (w_eff == SRC_W_W'(1));
    h_one = (h_eff == ROW_W'(1));
    nw    = w_one ? COL_W'(1) : w_eff[SRC_W_W-1:1];
    nh    = h_one ? ROW_W'(1) : {1'b0, h_eff[ROW_W-1:1]};
  end

  // decode colour to linear light in sRGB mode
  always_comb begin
    v.r = cfg.srgb_mode ? LIN_TAB[in_data.red_in]   : {{(LIN_W-8){1'b0}}, in_data.red_in};
    v.g = cfg.srgb_mode ? LIN_TAB[in_data.green_in] : {{(LIN_W-8){1'b0}}, in_data.green_in};
    v.b = cfg.srgb_mode ? LIN_TAB[in_data.blue_in]  : {{(LIN_W-8){1'b0}}, in_data.blue_in};
    v.a = in_data.alpha_in;
  end

  always_comb begin
    have_pair = 1'b0;
    hold_en   = 1'b0;
    nx        = '0;
    if (w_one) begin
      pair.r    = {v.r, 1'b0};
      pair.g    = {v.g, 1'b0};
      pair.b    = {v.b, 1'b0};
      pair.a    = {v.a, 1'b0};
      have_pair = 1'b1;
    end else begin
      pair.r = {1'b0, hold_r.r} + {1'b0, v.r};
      pair.g = {1'b0, hold_r.g} + {1'b0, v.g};
      pair.b = {1'b0, hold_r.b} + {1'b0, v.b};
      pair.a = {1'b0, hold_r.a} + {1'b0, v.a};
      // drop the last column of an odd width
      if ({1'b0, col_r} < {nw, 1'b0}) begin
        hold_en   = !col_r[0];
        have_pair = col_r[0];
        nx        = col_r[COL_W-1:1];
      end
    end
  end

  always_comb begin
    q_push      = 1'b0;
    q_item.op   = OP_DIRECT;
    q_item.addr = nx;
    q_item.pair = pair;
    ny          = h_one ? '0 : row_r[ROW_W-1:1];
    q_item.last = ({1'b0, nx} == nw - COL_W'(1)) && ({1'b0, ny} == nh - ROW_W'(1));
    if (accept && have_pair) begin
      if (h_one) begin
        q_push    = 1'b1;
        q_item.op = OP_DIRECT;
      end else if ({1'b0, row_r} < {nh, 1'b0}) begin
        q_push    = 1'b1;
        q_item.op = row_r[0] ? OP_COMBINE : OP_STORE;
      end
    end
  end

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (({1'b0, col_r} + SRC_W_W'(1)) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (({1'b0, row_r} + (ROW_W+1)'(1)) >= {1'b0, h_eff}) ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_en) hold_r <= v;
  end

endmodule

### rtl/mbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_back
// Row store, 2x2 averaging, sRGB re-encode by threshold search, and the
// result queue. Issue is credit based, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module mbd_back import mbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_empty,
  input  item_t    q_item,
  output logic     q_pop,
  output logic     out_empty,
  output pix_out_t out_data,
  input  logic     out_pop
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  pair_t              row_mem [PAIR_DEPTH];
  pair_t              rd_r;

  logic               issue;
  logic               take;
  logic               out_take;
  logic [OCNT_W-1:0]  credit_r;

  // stage 1: row store read
  logic               s1_v_r;
  op_t                s1_op_r;
  pair_t              s1_pair_r;
  logic               s1_last_r;

  // stage 2: means
  logic               s2_v_r;
  logic [LIN_W-1:0]   s2_m_r [3];
  logic [7:0]         s2_a_r;
  logic               s2_last_r;
  logic [TOT_W-1:0]   tot [3];
  logic [TOT_W-1:0]   rnd [3];
  logic [9:0]         tot_a;
  logic [9:0]         rnd_a;
  logic [PAIR_W-1:0]  s1_c [3];
  logic [PAIR_W-1:0]  rd_c [3];

  // encode: one code bit per stage
  logic [ENC_STEPS-1:0] e_v_r;
  logic [7:0]           e_code_r [ENC_STEPS][3];
  logic [7:0]           e_code_nxt [ENC_STEPS][3];
  logic [LIN_W-1:0]     e_m_r [ENC_STEPS][3];
  logic [7:0]           e_a_r [ENC_STEPS];
  logic                 e_last_r [ENC_STEPS];

  // result queue
  pix_out_t           out_mem [OUT_DEPTH];
  logic [OPTR_W-1:0]  out_wr_r;
  logic [OPTR_W-1:0]  out_rd_r;
  logic [OCNT_W-1:0]  out_cnt_r;
  pix_out_t           out_word;
  logic               out_push;

  // a store needs no result slot; everything else reserves one
  assign issue    = !q_empty &&
                    ((q_item.op == OP_STORE) || (credit_r < OCNT_W'(OUT_DEPTH)));
  assign take     = issue && (q_item.op != OP_STORE);
  assign q_pop    = issue;
  assign out_take = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      case ({take, out_take})
        2'b10:   credit_r <= credit_r + OCNT_W'(1);
        2'b01:   credit_r <= credit_r - OCNT_W'(1);
        default: credit_r <= credit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue && (q_item.op == OP_STORE)) row_mem[q_item.addr] <= q_item.pair;
    if (issue && (q_item.op == OP_COMBINE)) rd_r <= row_mem[q_item.addr];
  end

  always_ff @(posedge clk) begin
    s1_op_r   <= q_item.op;
    s1_pair_r <= q_item.pair;
    s1_last_r <= q_item.last;
  end

  always_comb begin
    s1_c[0] = s1_pair_r.r;
    s1_c[1] = s1_pair_r.g;
    s1_c[2] = s1_pair_r.b;
    rd_c[0] = rd_r.r;
    rd_c[1] = rd_r.g;
    rd_c[2] = rd_r.b;
    for (int c = 0; c < 3; c++) begin
      if (s1_op_r == OP_COMBINE) tot[c] = {1'b0, rd_c[c]} + {1'b0, s1_c[c]};
      else                       tot[c] = {s1_c[c], 1'b0};
      rnd[c] = tot[c] + TOT_W'(2);
    end
    if (s1_op_r == OP_COMBINE) tot_a = {1'b0, rd_r.a} + {1'b0, s1_pair_r.a};
    else                       tot_a = {s1_pair_r.a, 1'b0};
    rnd_a = tot_a + 10'd2;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) s2_m_r[c] <= rnd[c][TOT_W-1:2];
    s2_a_r    <= rnd_a[9:2];
    s2_last_r <= s1_last_r;
  end

  // binary search over the rising thresholds, MSB first
  always_comb begin
    logic [7:0]       code_in;
    logic [LIN_W-1:0] m_in;
    logic [7:0]       cand;
    for (int j = 0; j < ENC_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        code_in = (j == 0) ? 8'd0 : e_code_r[(j == 0) ? 0 : j - 1][c];
        m_in    = (j == 0) ? s2_m_r[c] : e_m_r[(j == 0) ? 0 : j - 1][c];
        cand    = code_in | (8'd1 << (ENC_STEPS - 1 - j));
        e_code_nxt[j][c] = (THR_TAB[cand] <= m_in) ? cand : code_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ENC_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        e_code_r[j][c] <= e_code_nxt[j][c];
        e_m_r[j][c]    <= (j == 0) ? s2_m_r[c] : e_m_r[(j == 0) ? 0 : j - 1][c];
      end
      e_a_r[j]    <= (j == 0) ? s2_a_r : e_a_r[(j == 0) ? 0 : j - 1];
      e_last_r[j] <= (j == 0) ? s2_last_r : e_last_r[(j == 0) ? 0 : j - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      e_v_r  <= '0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      e_v_r  <= {e_v_r[ENC_STEPS-2:0], s2_v_r};
    end
  end

  always_comb begin
    out_push = e_v_r[ENC_STEPS-1];
    if (cfg.srgb_mode) begin
      out_word.red_out   = e_code_r[ENC_STEPS-1][0];
      out_word.green_out = e_code_r[ENC_STEPS-1][1];
      out_word.blue_out  = e_code_r[ENC_STEPS-1][2];
    end else begin
      out_word.red_out   = e_m_r[ENC_STEPS-1][0][7:0];
      out_word.green_out = e_m_r[ENC_STEPS-1][1][7:0];
      out_word.blue_out  = e_m_r[ENC_STEPS-1][2][7:0];
    end
    out_word.alpha_out     = e_a_r[ENC_STEPS-1];
    out_word.last_of_image = e_last_r[ENC_STEPS-1];
  end

  assign out_empty = (out_cnt_r == '0);
  assign out_data  = out_mem[out_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r  <= '0;
      out_rd_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (out_push) out_wr_r <= out_wr_r + OPTR_W'(1);
      if (out_take) out_rd_r <= out_rd_r + OPTR_W'(1);
      case ({out_push, out_take})
        2'b10:   out_cnt_r <= out_cnt_r + OCNT_W'(1);
        2'b01:   out_cnt_r <= out_cnt_r - OCNT_W'(1);
        default: out_cnt_r <= out_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) out_mem[out_wr_r] <= out_word;
  end

endmodule

### rtl/mipmap_box_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// 2x2 box filter producing one half-size mip level from an RGBA8 stream.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock in raster order and keeps that rate as
// long as results are popped. After the pixel that completes its 2x2 block,
// a result word passes the registered read of the 2048-entry row store, the
// averaging adders and the bit-by-bit threshold search that re-encodes sRGB
// colour, and is then queued. Up to 16 result words are buffered; with the
// result side stalled, input backs up through a 4-word queue and then raises
// in_full. The row store needs no clearing after reset. Write the registers
// only while the block is idle; a write to any of the three registers
// restarts the image at its top-left pixel.
// ----------------------------------------------------------------------------
module mipmap_box_downsample import mbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  pix_in_t               in_data,
  output logic                  in_full,
  output logic                  out_empty,
  output pix_out_t              out_data,
  input  logic                  out_pop
);

  cfg_t  cfg_r;
  logic  restart;
  logic  q_push;
  item_t q_in_item;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_head;

  assign restart = cfg_we && ((cfg_index == CFG_SRC_WIDTH) ||
                              (cfg_index == CFG_SRC_HEIGHT) ||
                              (cfg_index == CFG_SRGB_MODE));
  assign in_full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= SRC_W_W'(1);
      cfg_r.src_height <= ROW_W'(1);
      cfg_r.srgb_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  cfg_r.src_width  <= cfg_data[SRC_W_W-1:0];
        CFG_SRC_HEIGHT: cfg_r.src_height <= cfg_data[ROW_W-1:0];
        CFG_SRGB_MODE:  cfg_r.srgb_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .restart (restart),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  mbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  mbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

  a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed a word into a full queue");

  a_queue_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("block not idle after reset");

endmodule

### dv/tb_mipmap_box_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mipmap_box_downsample
// Self-checking bench for the 2x2 box filter mip level generator.
// ----------------------------------------------------------------------------
// Streams RGBA8 source images through the queue-style ports and checks every
// downsampled word against a cycle-free model of the filter kept in a small
// scoreboard class. Covers linear and sRGB averaging, odd and unit
// dimensions, zero and oversized register values and back-to-back images,
// with random gaps on the push side and random stalls on the pop side.
// ----------------------------------------------------------------------------
module tb_mipmap_box_downsample;
  import mbd_pkg::*;

  localparam int DRAIN_CYCLES = 48;

  class mip_scoreboard;
    bit [LIN_W-1:0]  lin_of_code[256];
    bit [LIN_W-1:0]  code_floor[256];
    bit [SRC_W_W-1:0] width_reg;
    bit [ROW_W-1:0]  height_reg;
    bit              srgb_reg;
    int unsigned     col_cnt;
    int unsigned     row_cnt;
    bit [LIN_W-1:0]  left_hold[4];
    bit [PAIR_W-1:0] row_sums[PAIR_DEPTH][4];
    pix_out_t        expected_pixels[$];
    int              errors;
    int              pixels_in;
    int              words_out;

    function new();
      int k;
      for (k = 0; k < 256; k++) begin
        lin_of_code[k] = LIN_W'(srgb_level_linear(2 * k));
        code_floor[k]  = (k == 0) ? '0 : LIN_W'(srgb_level_linear(2 * k - 1));
      end
      width_reg  = 1;
      height_reg = 1;
      srgb_reg   = 0;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
      pixels_in  = 0;
      words_out  = 0;
    endfunction

    function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
    endfunction

    function longint unsigned fifth_power(longint unsigned r);
      longint unsigned p;
      p = q30_mul(r, r);
      p = q30_mul(p, r);
      p = q30_mul(p, r);
      return q30_mul(p, r);
    endfunction

    // Linear light of sRGB level n/510 in 0.16 fixed point.
    function longint unsigned srgb_level_linear(int unsigned n);
      longint unsigned scale, nn, x, q, r, trial;
      int b;
      scale = (64'd1 << LINEAR_BITS) - 64'd1;
      nn = 64'(n);
      if (nn <= 64'd20) return (nn * 64'd200 * scale + 64'd658920) / 64'd1317840;
      x = ((nn * 64'd1000 + 64'd28050) << 30) / 64'd538050;
      q = q30_mul(x, x);
      // largest r with r^5 <= q; the floored chain is monotone in r
      if (fifth_power(64'd1 << 30) <= q) begin
        r = 64'd1 << 30;
      end else begin
        r = 0;
        for (b = 29; b >= 0; b--) begin
          trial = r | (64'd1 << b);
          if (fifth_power(trial) <= q) r = trial;
        end
      end
      return (q30_mul(q, r) * scale + (64'd1 << 29)) >> 30;
    endfunction

    function bit [7:0] linear_to_code(int unsigned m);
      int k;
      int unsigned code;
      code = 0;
      for (k = 1; k < 256; k++) if (code_floor[k] <= m) code++;
      return code[7:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SRC_WIDTH:  width_reg  = d[SRC_W_W-1:0];
        CFG_SRC_HEIGHT: height_reg = d[ROW_W-1:0];
        CFG_SRGB_MODE:  srgb_reg   = d[0];
        default:        return;
      endcase
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    // Advance the model by one accepted source pixel.
    function void note_source_pixel(pix_in_t p);
      int unsigned     w, h, nw, nh, x, y, nx, ny, m;
      bit [LIN_W-1:0]  v[4];
      bit [PAIR_W-1:0] pr[4];
      bit [TOT_W-1:0]  tot[4];
      bit [7:0]        code[3];
      bit              paired, emit;
      pix_out_t        e;
      int              i;
      pixels_in++;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      nw = (w > 1) ? w / 2 : 1;
      nh = (h > 1) ? h / 2 : 1;
      x = col_cnt;
      y = row_cnt;
      nx = 0;
      paired = 0;
      emit = 0;
      v[0] = srgb_reg ? lin_of_code[p.red_in]   : LIN_W'(p.red_in);
      v[1] = srgb_reg ? lin_of_code[p.green_in] : LIN_W'(p.green_in);
      v[2] = srgb_reg ? lin_of_code[p.blue_in]  : LIN_W'(p.blue_in);
      v[3] = LIN_W'(p.alpha_in);

      if (w == 1) begin
        for (i = 0; i < 4; i++) pr[i] = {v[i], 1'b0};
        paired = 1;
      end else if (x < 2 * nw) begin
        if (x[0] == 1'b0) begin
          left_hold = v;
        end else begin
          for (i = 0; i < 4; i++) pr[i] = left_hold[i] + v[i];
          nx = x >> 1;
          paired = 1;
        end
      end

      if (paired) begin
        if (h == 1) begin
          for (i = 0; i < 4; i++) tot[i] = {pr[i], 1'b0};
          emit = 1;
        end else if (y < 2 * nh) begin
          if (y[0] == 1'b0) begin
            row_sums[nx] = pr;
          end else begin
            for (i = 0; i < 4; i++) tot[i] = row_sums[nx][i] + pr[i];
            emit = 1;
          end
        end
      end

      if (emit) begin
        ny = (h == 1) ? 0 : (y >> 1);
        for (i = 0; i < 3; i++) begin
          m = (32'(tot[i]) + 2) >> 2;
          code[i] = srgb_reg ? linear_to_code(m) : m[7:0];
        end
        m = (32'(tot[3]) + 2) >> 2;
        e.red_out       = code[0];
        e.green_out     = code[1];
        e.blue_out      = code[2];
        e.alpha_out     = m[7:0];
        e.last_of_image = (nx == nw - 1) && (ny == nh - 1);
        expected_pixels = {expected_pixels, e};
      end

      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col_cnt = x;
      row_cnt = y;
    endfunction

    function void compare_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_mip_pixel(pix_out_t got);
      pix_out_t e;
      words_out++;
      if (expected_pixels.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      compare_field("red_out", e.red_out, got.red_out);
      compare_field("green_out", e.green_out, got.green_out);
      compare_field("blue_out", e.blue_out, got.blue_out);
      compare_field("alpha_out", e.alpha_out, got.alpha_out);
      compare_field("last_of_image", {7'd0, e.last_of_image}, {7'd0, got.last_of_image});
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_push;
  pix_in_t               in_data;
  logic                  in_full;
  logic                  out_empty;
  pix_out_t              out_data;
  logic                  out_pop;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int settings_done = 0;
  mip_scoreboard sb = new();

  mipmap_box_downsample DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_mip_pixel(out_data);
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_idle_pct = 52; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 52; end
      default: begin send_idle_pct = 7; pop_stall_pct = 7; end
    endcase
  endtask

  task automatic send_pixel(input pix_in_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_source_pixel(p);
  endtask

  // Drop push, wait for every expected word, then let the pipeline settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
                            input logic [CFG_DATA_W-1:0] sv);
    logic [CFG_DATA_W-1:0] vals[3];
    logic [CFG_IDX_W-1:0]  idxs[3];
    int i;
    vals = '{wv, hv, sv};
    idxs = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_SRGB_MODE};
    for (i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  initial begin
    bit [7:0] ramp_codes[10];
    pix_in_t  p;
    int       i, n, phase, rand_pixels, total;
    int unsigned wv, hv, weff, heff;
    ramp_codes = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd10, 8'd11, 8'd128, 8'd200, 8'd254, 8'd255};
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SRC_WIDTH;
    cfg_data  <= '0;
    in_push   <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1x1 image, raw averaging, every pixel is its own word
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hAA55_AA55);
    send_pixel(32'h55AA_55AA);
    wait_idle();

    // sRGB round trip through the curve at the dark and bright ends
    set_config(16'd1, 16'd1, 16'd1);
    for (i = 0; i < 10; i++) begin
      p.red_in   = ramp_codes[i];
      p.green_in = 8'd255 - ramp_codes[i];
      p.blue_in  = ramp_codes[i] ^ 8'h55;
      p.alpha_in = ramp_codes[i];
      send_pixel(p);
    end
    wait_idle();

    // zero dimensions count as one
    set_config(16'd0, 16'd0, 16'd1);
    send_pixel(32'h10F0_8040);
    send_pixel(32'hFF00_FF00);
    wait_idle();

    // odd width and height: drop the last column and row
    set_config(16'd3, 16'd3, 16'd1);
    for (i = 0; i < 9; i++) send_pixel(pix_in_t'($urandom));
    wait_idle();

    // oversized width saturates; single row, only its start
    set_idle(3);
    set_config(16'hFFFF, 16'd1, 16'd1);
    for (i = 0; i < 200; i++) send_pixel(pix_in_t'($urandom));
    wait_idle();
    // tallest image, only the top part
    set_config(16'd2, 16'hFFFF, 16'hFFFE);
    for (i = 0; i < 120; i++) send_pixel(pix_in_t'($urandom));
    wait_idle();

    // random small images, several per setting, some cut short
    phase = 0;
    rand_pixels = 0;
    while (rand_pixels < 450) begin
      set_idle(phase % 4);
      wv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      hv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
      set_config(CFG_DATA_W'(wv), CFG_DATA_W'(hv), CFG_DATA_W'($urandom));
      weff = (wv == 0) ? 1 : wv;
      heff = (hv == 0) ? 1 : hv;
      total = $urandom_range(1, 3) * weff * heff;
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      for (n = 0; n < total; n++) send_pixel(pix_in_t'($urandom));
      rand_pixels += total;
      wait_idle();
      phase++;
    end

    $display("Run covered %0d source pixels and %0d mip words over %0d register settings,",
             sb.pixels_in, sb.words_out, settings_done);
    $display("including a saturated width, unit and odd sizes, and both colour modes.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
rtl/mbd_pkg.sv
rtl/mbd_queue.sv
rtl/mbd_front.sv
rtl/mbd_back.sv
rtl/mipmap_box_downsample.sv
dv/tb_mipmap_box_downsample.sv
